// ----- src/cmseed_pkg.sv -----
// Shared constants for the class-center seeding block.
// Widths, limits and register map; no dependencies.
package cmseed_pkg;

   // statistic accumulators
   localparam int CNT_W      = 21;
   localparam int SUM_W      = 28;
   localparam int SQ_W       = 36;
   localparam int MAX_PIXELS = 1048576;

   // fixed point and result fields
   localparam int FRAC_BITS   = 8;
   localparam int MAX_CLASSES = 16;
   localparam int CC_W        = 5;
   localparam int IDX_W       = 4;
   localparam int MEAN_W      = 19;
   localparam int VAR_W       = 13;
   localparam logic [VAR_W-1:0] VARIANCE_Q = VAR_W'(20 << FRAC_BITS);

   // arithmetic datapath widths
   localparam int PROD_W   = 57;              // n*sumsq and sum^2
   localparam int MPLIER_W = 28;              // shift-add multiplier operand
   localparam int NN_W     = 41;              // n^2 up to 2^40, also divisor width
   localparam int DVD_W    = 72;              // dividend/quotient shift register
   localparam int VARQ_W   = 32;              // variance, Q(2F)
   localparam int MEANQ_W  = 16;              // mean, QF
   localparam int SIG_W    = 16;              // sigma, QF
   localparam int SQR_W    = 33;              // root partial result

   // sequencer step counts
   localparam int STEP_W      = 7;
   localparam int MUL_STEPS   = 28;
   localparam int DIVV_STEPS  = 72;
   localparam int DIVM_STEPS  = 36;
   localparam int SQRT_STEPS  = 16;

   // stream payloads
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_CLASS_COUNT = 1'b0;
   localparam logic [CC_W-1:0] CLASS_COUNT_RESET = 5'd2;

endpackage

// ----- src/class_mean_seed_from_image_stats_core.sv -----
// Class-center seeding core: accumulates pixel statistics, then derives the
// mean and standard deviation and streams out the initial class centers.
// Depends on cmseed_pkg.
//
// Pixels: one transfer per cycle while accumulating (req_tready high).
// After the last pixel one shared shift-add multiplier runs three products,
// one restoring divider runs the variance and the mean, and a bit-pair
// square root derives sigma from the variance. The first center is valid
// after the solve, then one center per cycle as rsp_tready allows.
// req_tready stays low until every center is loaded and the store is
// cleared for the next image.
// Reset (synchronous, active high) clears the statistics, sets class_count
// to 2 and drops rsp_tvalid; no clearing pass is needed.
module class_mean_seed_from_image_stats_core (
   input  logic                               clock,
   input  logic                               reset,
   // pixel stream; tdata[7:0] = pixel, tlast = last pixel of the image
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cmseed_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                               req_tlast,
   // center stream; tdata[3:0] = class_index, [22:4] = class_mean,
   // [35:23] = class_variance, [39:36] = zero; tlast = final_res
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cmseed_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                               rsp_tlast,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cmseed_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cmseed_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cmseed_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import cmseed_pkg::*;

   typedef enum logic [2:0] {
      ST_ACCUM,   // taking pixels
      ST_MUL_A,   // n * sumsq
      ST_MUL_B,   // sum * sum, forms the variance numerator
      ST_MUL_N,   // n * n
      ST_DIV_V,   // numerator * 2^2F / n^2
      ST_DIV_M,   // sum * 2^F / n
      ST_SQRT,    // sigma = isqrt(var)
      ST_EMIT     // one center per transfer
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SQ_W-1:0]         sumsq_ff, sumsq_in;
   logic [CC_W-1:0]         class_count_ff, class_count_in;
   logic [STEP_W-1:0]       step_ff, step_in;

   logic [PROD_W-1:0]       acc_ff, acc_in;        // multiplier accumulator
   logic [PROD_W-1:0]       mcand_ff, mcand_in;    // shifted multiplicand
   logic [MPLIER_W-1:0]     mplier_ff, mplier_in;  // multiplier bits, LSB first
   logic [PROD_W-1:0]       diff_ff, diff_in;      // N*sumsq - sum^2
   logic [NN_W-1:0]         nn_ff, nn_in;

   logic [DVD_W-1:0]        dvd_ff, dvd_in;        // dividend in, quotient out
   logic [NN_W-1:0]         rem_ff, rem_in;

   logic [VARQ_W-1:0]       var_ff, var_in;
   logic [MEANQ_W-1:0]      mean_ff, mean_in;
   logic [SIG_W-1:0]        sigma_ff, sigma_in;
   logic [VARQ_W-1:0]       sqv_ff, sqv_in;        // root radicand remainder
   logic [SQR_W-1:0]        sqres_ff, sqres_in;

   logic [CC_W-1:0]         idx_ff, idx_in;        // next class to send
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [MEAN_W-1:0]       rsp_mean_ff, rsp_mean_in;
   logic                    rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------ datapath
   logic                    csr_wr;
   logic [2*REQ_DATA_W-1:0] px_sq;
   logic [PROD_W-1:0]       mul_sum;
   logic [NN_W-1:0]         dvs;
   logic [NN_W:0]           div_top;
   logic [NN_W:0]           div_diff;
   logic                    div_ge;
   logic [NN_W-1:0]         rem_next;
   logic [DVD_W-1:0]        dvd_next;
   logic [SQR_W-1:0]        sq_bit;
   logic [SQR_W-1:0]        sq_try;
   logic                    sq_ge;
   logic [SQR_W-1:0]        sqres_next;
   logic [CC_W-1:0]         cc;
   logic [CC_W-2:0]         half;
   logic signed [5:0]       em_m;
   logic signed [22:0]      em_prod;
   logic signed [23:0]      em_t;
   logic                    em_load;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign px_sq  = req_tdata * req_tdata;

   // shared shift-add multiplier: one partial product per cycle
   assign mul_sum = acc_ff + (mplier_ff[0] ? mcand_ff : '0);

   // restoring divider: one quotient bit per cycle
   assign dvs      = (state_ff == ST_DIV_V) ? nn_ff : NN_W'(cnt_ff);
   assign div_top  = {rem_ff, dvd_ff[DVD_W-1]};
   assign div_diff = div_top - {1'b0, dvs};
   assign div_ge   = (div_top >= {1'b0, dvs});
   assign rem_next = div_ge ? div_diff[NN_W-1:0] : div_top[NN_W-1:0];
   assign dvd_next = {dvd_ff[DVD_W-2:0], div_ge};

   // integer square root, one result bit per cycle, bit = 4^(15-step)
   assign sq_bit     = SQR_W'(1) << {~step_ff[3:0], 1'b0};
   assign sq_try     = sqres_ff + sq_bit;
   assign sq_ge      = ({1'b0, sqv_ff} >= sq_try);
   assign sqres_next = sq_ge ? ((sqres_ff >> 1) + sq_bit) : (sqres_ff >> 1);

   // center = floor(mean + m*sigma/2); m skips zero for an even count
   assign cc      = (class_count_ff > CC_W'(MAX_CLASSES)) ? CC_W'(MAX_CLASSES)
                                                         : class_count_ff;
   assign half    = cc[CC_W-1:1];
   assign em_m    = 6'(idx_ff) - 6'(half)
                  + ((!cc[0] && (idx_ff >= CC_W'(half))) ? 6'sd1 : 6'sd0);
   assign em_prod = em_m * $signed({1'b0, sigma_ff});
   assign em_t    = $signed({7'b0, mean_ff, 1'b0}) + $signed({em_prod[22], em_prod});
   assign em_load = (state_ff == ST_EMIT) && (idx_ff != cc)
                  && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      sum_in         = sum_ff;
      sumsq_in       = sumsq_ff;
      class_count_in = class_count_ff;
      step_in        = step_ff;
      acc_in         = acc_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      diff_in        = diff_ff;
      nn_in          = nn_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      var_in         = var_ff;
      mean_in        = mean_ff;
      sigma_in       = sigma_ff;
      sqv_in         = sqv_ff;
      sqres_in       = sqres_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_index_in   = rsp_index_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_wr && (csr_paddr[2] == REG_CLASS_COUNT)) begin
         class_count_in = csr_pwdata[CC_W-1:0];
      end

      case (state_ff)
         ST_ACCUM: begin
            if (req_tvalid) begin
               if (cnt_ff < CNT_W'(MAX_PIXELS)) begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  sum_in   = sum_ff + SUM_W'(req_tdata);
                  sumsq_in = sumsq_ff + SQ_W'(px_sq);
               end
               if (req_tlast) begin
                  step_in = '0;
                  idx_in  = '0;
                  if (cnt_in == '0) begin
                     // empty image: every center sits at zero
                     mean_in  = '0;
                     sigma_in = '0;
                     var_in   = '0;
                     state_in = ST_EMIT;
                  end else begin
                     acc_in    = '0;
                     mcand_in  = PROD_W'(sumsq_in);
                     mplier_in = MPLIER_W'(cnt_in);
                     state_in  = ST_MUL_A;
                  end
               end
            end
         end
         ST_MUL_A, ST_MUL_B, ST_MUL_N: begin
            acc_in    = mul_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               step_in = '0;
               acc_in  = '0;
               if (state_ff == ST_MUL_A) begin
                  diff_in   = mul_sum;
                  mcand_in  = PROD_W'(sum_ff);
                  mplier_in = MPLIER_W'(sum_ff);
                  state_in  = ST_MUL_B;
               end else if (state_ff == ST_MUL_B) begin
                  diff_in   = (diff_ff > mul_sum) ? (diff_ff - mul_sum) : '0;
                  mcand_in  = PROD_W'(cnt_ff);
                  mplier_in = MPLIER_W'(cnt_ff);
                  state_in  = ST_MUL_N;
               end else begin
                  nn_in    = mul_sum[NN_W-1:0];
                  dvd_in   = {diff_ff[DVD_W-2*FRAC_BITS-1:0], {(2*FRAC_BITS){1'b0}}};
                  rem_in   = '0;
                  state_in = ST_DIV_V;
               end
            end
         end
         ST_DIV_V: begin
            dvd_in  = dvd_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIVV_STEPS - 1)) begin
               var_in   = dvd_next[VARQ_W-1:0];
               dvd_in   = {sum_ff, {FRAC_BITS{1'b0}},
                           {(DVD_W-SUM_W-FRAC_BITS){1'b0}}};
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV_M;
            end
         end
         ST_DIV_M: begin
            dvd_in  = dvd_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIVM_STEPS - 1)) begin
               mean_in  = dvd_next[MEANQ_W-1:0];
               sqv_in   = var_ff;
               sqres_in = '0;
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               sqv_in = sqv_ff - sq_try[VARQ_W-1:0];
            end
            sqres_in = sqres_next;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               sigma_in = sqres_next[SIG_W-1:0];
               step_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (idx_ff == cc) begin
               // run done (or no classes): clear the store for the next image
               cnt_in   = '0;
               sum_in   = '0;
               sumsq_in = '0;
               state_in = ST_ACCUM;
            end else if (em_load) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff[IDX_W-1:0];
               rsp_mean_in  = em_t[MEAN_W:1];
               rsp_last_in  = ((idx_ff + CC_W'(1)) == cc);
               idx_in       = idx_ff + CC_W'(1);
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_ACCUM;
         cnt_ff         <= '0;
         sum_ff         <= '0;
         sumsq_ff       <= '0;
         class_count_ff <= CLASS_COUNT_RESET;
         step_ff        <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         sum_ff         <= sum_in;
         sumsq_ff       <= sumsq_in;
         class_count_ff <= class_count_in;
         step_ff        <= step_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      diff_ff      <= diff_in;
      nn_ff        <= nn_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      var_ff       <= var_in;
      mean_ff      <= mean_in;
      sigma_ff     <= sigma_in;
      sqv_ff       <= sqv_in;
      sqres_ff     <= sqres_in;
      rsp_index_ff <= rsp_index_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ------------------------------------------------------------- outputs
   assign req_tready = (state_ff == ST_ACCUM);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-IDX_W-MEAN_W-VAR_W){1'b0}},
                        VARIANCE_Q, rsp_mean_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CLASS_COUNT)
                     ? CSR_DATA_W'(class_count_ff) : '0;

   // ---------------------------------------------------------- assertions
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel count beyond limit");

   a_nn_product: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_V) |-> (42'(nn_ff) == 42'(cnt_ff) * 42'(cnt_ff)))
      else $error("n squared wrong during variance divide");

   a_mean_quot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && idx_ff == '0 && cnt_ff != '0) |->
      ((37'(mean_ff) * 37'(cnt_ff) <= 37'({sum_ff, {FRAC_BITS{1'b0}}})) &&
       ((37'(mean_ff) + 37'd1) * 37'(cnt_ff) > 37'({sum_ff, {FRAC_BITS{1'b0}}}))))
      else $error("mean is not the floored quotient");

   a_sigma_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && idx_ff == '0) |->
      ((34'(sigma_ff) * 34'(sigma_ff) <= 34'(var_ff)) &&
       ((34'(sigma_ff) + 34'd1) * (34'(sigma_ff) + 34'd1) > 34'(var_ff))))
      else $error("sigma is not the floored root");

endmodule
